// ===== hdl/lsv_pkg.sv =====
// ----------------------------------------------------------------------------
// lsv_pkg
// Shared types and constants for the L-shape outline pipeline: angle
// reduction, Taylor series divisors and their reciprocals, beat payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package lsv_pkg;

  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;

  localparam int               NIT     = 6;
  localparam logic [30:0]      Q30_ONE = 31'h4000_0000;

  localparam logic [15:0] FULL_TURN    = 16'd36000;
  localparam logic [15:0] THREE_QTR    = 16'd27000;
  localparam logic [15:0] HALF_TURN    = 16'd18000;
  localparam logic [15:0] QUARTER_TURN = 16'd9000;
  localparam logic [15:0] EIGHTH_TURN  = 16'd4500;

  // pi in Q30 over 18000 split into whole and fractional parts
  localparam logic [31:0] PI_STEP   = 32'd187403;
  localparam logic [31:0] PI_FRAC   = 32'd5426;
  localparam logic [31:0] ANG_HALF  = 32'd9000;
  localparam logic [31:0] ANG_DIV   = 32'd18000;
  localparam logic [17:0] ANG_RECIP = 18'((64'd1 << 32) / 64'd18000);

  localparam logic [31:0] COS_DIV [NIT] = '{32'd132, 32'd90, 32'd56, 32'd30, 32'd12, 32'd2};
  localparam logic [31:0] COS_RECIP [NIT] = '{
    32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
    32'((64'd1 << 32) / 64'd56),  32'((64'd1 << 32) / 64'd30),
    32'((64'd1 << 32) / 64'd12),  32'((64'd1 << 32) / 64'd2)};

  localparam logic [31:0] SIN_DIV [NIT-1] = '{32'd110, 32'd72, 32'd42, 32'd20, 32'd6};
  localparam logic [31:0] SIN_RECIP [NIT-1] = '{
    32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
    32'((64'd1 << 32) / 64'd42),  32'((64'd1 << 32) / 64'd20),
    32'((64'd1 << 32) / 64'd6)};

  localparam logic [2:0] LAST_CORNER = 3'd5;

  localparam logic [1:0] REG_LONG_LENGTH     = 2'd0;
  localparam logic [1:0] REG_SHORT_LENGTH    = 2'd1;
  localparam logic [1:0] REG_LONG_ARM_WIDTH  = 2'd2;
  localparam logic [1:0] REG_SHORT_ARM_WIDTH = 2'd3;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic        [1:0]  quad;
    logic               swap;
  } side_t;

  typedef struct packed {
    logic signed [19:0]       px;
    logic signed [19:0]       py;
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } pose_t;

endpackage

`default_nettype wire

// ===== hdl/lsv_sincos.sv =====
// ----------------------------------------------------------------------------
// lsv_sincos
// Pipelined sine and cosine of a heading: octant reduction, Q30 angle,
// Taylor series one term per three stages, rounding and quadrant mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module lsv_sincos (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic        [15:0] in_heading,
  input  wire logic signed [19:0] in_px,
  input  wire logic signed [19:0] in_py,
  output logic                    out_valid,
  output lsv_pkg::pose_t          out_pose
);

  localparam int F   = lsv_pkg::TRIG_FRAC_BITS;
  localparam int NIT = lsv_pkg::NIT;

  // stage 1: wrap heading
  logic v1_r;
  logic [15:0] h1_r;
  lsv_pkg::side_t sd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_r     <= (in_heading >= lsv_pkg::FULL_TURN) ? in_heading - lsv_pkg::FULL_TURN
                                                     : in_heading;
      sd1_r.px   <= in_px;
      sd1_r.py   <= in_py;
      sd1_r.quad <= lsv_pkg::QUAD_0;
      sd1_r.swap <= 1'b0;
    end
  end

  // stage 2: quadrant and octant fold
  logic v2_r;
  logic [12:0] rr2_r;
  lsv_pkg::side_t sd2_r;
  logic [15:0] r2;
  logic [1:0]  q2;

  always_comb begin
    if (h1_r >= lsv_pkg::THREE_QTR) begin
      q2 = lsv_pkg::QUAD_3;
      r2 = h1_r - lsv_pkg::THREE_QTR;
    end else if (h1_r >= lsv_pkg::HALF_TURN) begin
      q2 = lsv_pkg::QUAD_2;
      r2 = h1_r - lsv_pkg::HALF_TURN;
    end else if (h1_r >= lsv_pkg::QUARTER_TURN) begin
      q2 = lsv_pkg::QUAD_1;
      r2 = h1_r - lsv_pkg::QUARTER_TURN;
    end else begin
      q2 = lsv_pkg::QUAD_0;
      r2 = h1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr2_r <= (r2 > lsv_pkg::EIGHTH_TURN) ? 13'(lsv_pkg::QUARTER_TURN - r2) : 13'(r2);
      sd2_r.px   <= sd1_r.px;
      sd2_r.py   <= sd1_r.py;
      sd2_r.quad <= q2;
      sd2_r.swap <= (r2 > lsv_pkg::EIGHTH_TURN);
    end
  end

  // stage 3: angle partial products
  logic v3_r;
  logic [29:0] base3_r;
  logic [24:0] p3_r;
  lsv_pkg::side_t sd3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base3_r <= 30'(32'(rr2_r) * lsv_pkg::PI_STEP);
      p3_r    <= 25'(32'(rr2_r) * lsv_pkg::PI_FRAC + lsv_pkg::ANG_HALF);
      sd3_r   <= sd2_r;
    end
  end

  // stage 4: reciprocal estimate of the fractional quotient
  logic v4_r;
  logic [29:0] base4_r;
  logic [24:0] p4_r;
  logic [10:0] q4_r;
  lsv_pkg::side_t sd4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q4_r    <= 11'((43'(p3_r) * 43'(lsv_pkg::ANG_RECIP)) >> 32);
      p4_r    <= p3_r;
      base4_r <= base3_r;
      sd4_r   <= sd3_r;
    end
  end

  // stage 5: correct quotient, form Q30 angle
  logic v5_r;
  logic [29:0] x5_r;
  lsv_pkg::side_t sd5_r;
  logic [24:0] rem5;

  assign rem5 = p4_r - 25'(32'(q4_r) * lsv_pkg::ANG_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x5_r  <= base4_r + 30'(q4_r) + 30'(32'(rem5) >= lsv_pkg::ANG_DIV);
      sd5_r <= sd4_r;
    end
  end

  // stage 6 feeds the series chain
  logic           ch_v_r    [NIT+1];
  lsv_pkg::side_t ch_side_r [NIT+1];
  logic [29:0]    ch_x_r    [NIT+1];
  logic [29:0]    ch_x2_r   [NIT+1];
  logic [30:0]    ch_tc_r   [NIT+1];
  logic [30:0]    ch_ts_r   [1:NIT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_v_r[0] <= 1'b0;
    end else if (en) begin
      ch_v_r[0] <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch_x2_r[0]   <= 30'((60'(x5_r) * 60'(x5_r)) >> 30);
      ch_x_r[0]    <= x5_r;
      ch_tc_r[0]   <= lsv_pkg::Q30_ONE;
      ch_side_r[0] <= sd5_r;
    end
  end

  for (genvar i = 0; i < NIT; i++) begin : g_term
    logic           va_r, vb_r;
    lsv_pkg::side_t a_side_r, b_side_r;
    logic [29:0]    a_x_r, a_x2_r, a_nc_r;
    logic [29:0]    b_x_r, b_x2_r, b_nc_r, b_qc_r;
    logic [29:0]    remc;

    assign remc = b_nc_r - 30'(62'(b_qc_r) * 62'(lsv_pkg::COS_DIV[i]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r        <= 1'b0;
        vb_r        <= 1'b0;
        ch_v_r[i+1] <= 1'b0;
      end else if (en) begin
        va_r        <= ch_v_r[i];
        vb_r        <= va_r;
        ch_v_r[i+1] <= vb_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_nc_r   <= 30'((61'(ch_x2_r[i]) * 61'(ch_tc_r[i])) >> 30);
        a_x_r    <= ch_x_r[i];
        a_x2_r   <= ch_x2_r[i];
        a_side_r <= ch_side_r[i];
        b_qc_r   <= 30'((62'(a_nc_r) * 62'(lsv_pkg::COS_RECIP[i])) >> 32);
        b_nc_r   <= a_nc_r;
        b_x_r    <= a_x_r;
        b_x2_r   <= a_x2_r;
        b_side_r <= a_side_r;
        ch_tc_r[i+1]   <= lsv_pkg::Q30_ONE
                          - 31'(b_qc_r + 30'(32'(remc) >= lsv_pkg::COS_DIV[i]));
        ch_x_r[i+1]    <= b_x_r;
        ch_x2_r[i+1]   <= b_x2_r;
        ch_side_r[i+1] <= b_side_r;
      end
    end

    if (i == 0) begin : g_sin_start
      always_ff @(posedge clk) begin
        if (en) begin
          ch_ts_r[1] <= lsv_pkg::Q30_ONE;
        end
      end
    end else begin : g_sin_term
      logic [29:0] a_ns_r, b_ns_r, b_qs_r;
      logic [29:0] rems;

      assign rems = b_ns_r - 30'(62'(b_qs_r) * 62'(lsv_pkg::SIN_DIV[i-1]));

      always_ff @(posedge clk) begin
        if (en) begin
          a_ns_r <= 30'((61'(ch_x2_r[i]) * 61'(ch_ts_r[i])) >> 30);
          b_qs_r <= 30'((62'(a_ns_r) * 62'(lsv_pkg::SIN_RECIP[i-1])) >> 32);
          b_ns_r <= a_ns_r;
          if (i < NIT - 1) begin
            ch_ts_r[i+1] <= lsv_pkg::Q30_ONE
                            - 31'(b_qs_r + 30'(32'(rems) >= lsv_pkg::SIN_DIV[i-1]));
          end else begin
            ch_ts_r[NIT] <= lsv_pkg::Q30_ONE
                            - 31'(b_qs_r + 30'(32'(rems) >= lsv_pkg::SIN_DIV[i-1]));
          end
        end
      end
    end
  end

  // final sine product
  logic v7_r;
  logic [29:0] sin7_r;
  logic [30:0] cos7_r;
  lsv_pkg::side_t sd7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= ch_v_r[NIT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin7_r <= 30'((61'(ch_x_r[NIT]) * 61'(ch_ts_r[NIT])) >> 30);
      cos7_r <= ch_tc_r[NIT];
      sd7_r  <= ch_side_r[NIT];
    end
  end

  // round to trig format and map to quadrant
  localparam logic [31:0] TRIG_RND = 32'(1) << (29 - F);

  logic [F:0] sin_q, cos_q;
  logic signed [lsv_pkg::TRIG_W-1:0] s0, c0, s_nxt, c_nxt;

  assign sin_q = (F+1)'((32'(sin7_r) + TRIG_RND) >> (30 - F));
  assign cos_q = (F+1)'((32'(cos7_r) + TRIG_RND) >> (30 - F));

  always_comb begin
    if (sd7_r.swap) begin
      s0 = $signed({1'b0, cos_q});
      c0 = $signed({1'b0, sin_q});
    end else begin
      s0 = $signed({1'b0, sin_q});
      c0 = $signed({1'b0, cos_q});
    end
    case (sd7_r.quad)
      lsv_pkg::QUAD_0: begin s_nxt = s0;  c_nxt = c0;  end
      lsv_pkg::QUAD_1: begin s_nxt = c0;  c_nxt = -s0; end
      lsv_pkg::QUAD_2: begin s_nxt = -s0; c_nxt = -c0; end
      default:         begin s_nxt = -c0; c_nxt = s0;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pose.px <= sd7_r.px;
      out_pose.py <= sd7_r.py;
      out_pose.s  <= s_nxt;
      out_pose.c  <= c_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/l_shape_pose_to_vertices_top.sv =====
// Throughput: one corner beat per cycle while out_ready does not stall the
// output; the corner sequencer replays each pose six times, one beat per
// corner, and accepts no new pose until its last corner moves on.
// Reset: synchronous, active low; clears valid bits and loads the default
// outline registers (150, 100, 40, 40).
// ----------------------------------------------------------------------------
// l_shape_pose_to_vertices_top
// Places an L-shaped outline at a pose and emits its six corners, one per
// beat, rotated by the heading and rounded to the coordinate grid.
// ----------------------------------------------------------------------------
`default_nettype none

module l_shape_pose_to_vertices_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [19:0] in_pos_x,
  input  wire logic signed [19:0] in_pos_y,
  input  wire logic        [15:0] in_heading,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [2:0]  out_corner_index,
  output logic signed      [19:0] out_corner_x,
  output logic signed      [19:0] out_corner_y,
  output logic                    out_last_corner,
  input  wire logic               cfg_we,
  input  wire logic        [1:0]  cfg_index,
  input  wire logic        [11:0] cfg_data
);

  localparam int F  = lsv_pkg::TRIG_FRAC_BITS;

  logic [11:0] long_len_r, short_len_r, long_arm_r, short_arm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_len_r  <= 12'd150;
      short_len_r <= 12'd100;
      long_arm_r  <= 12'd40;
      short_arm_r <= 12'd40;
    end else if (cfg_we) begin
      case (cfg_index)
        lsv_pkg::REG_LONG_LENGTH:    long_len_r  <= cfg_data;
        lsv_pkg::REG_SHORT_LENGTH:   short_len_r <= cfg_data;
        lsv_pkg::REG_LONG_ARM_WIDTH: long_arm_r  <= cfg_data;
        default:                     short_arm_r <= cfg_data;
      endcase
    end
  end

  logic back_en, front_en;
  logic sc_valid;
  lsv_pkg::pose_t sc_pose;

  logic hold_v_r;
  lsv_pkg::pose_t hold_r;
  logic [2:0] k_r;

  assign back_en  = !out_valid || out_ready;
  assign front_en = !hold_v_r || (back_en && (k_r == lsv_pkg::LAST_CORNER));
  assign in_ready = front_en;

  lsv_sincos u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (front_en),
    .in_valid  (in_valid),
    .in_heading(in_heading),
    .in_px     (in_pos_x),
    .in_py     (in_pos_y),
    .out_valid (sc_valid),
    .out_pose  (sc_pose)
  );

  // corner sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      k_r      <= 3'd0;
    end else if (front_en) begin
      hold_v_r <= sc_valid;
      k_r      <= 3'd0;
    end else if (back_en) begin
      k_r <= k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      hold_r <= sc_pose;
    end
  end

  logic signed [13:0] a_n, a_p, b_n, b_p, u_arm, v_arm, u_nxt, v_nxt;

  assign a_p   = $signed({2'b00, short_len_r});
  assign a_n   = -a_p;
  assign b_p   = $signed({2'b00, long_len_r});
  assign b_n   = -b_p;
  assign u_arm = $signed({1'b0, short_arm_r, 1'b0}) - a_p;
  assign v_arm = $signed({1'b0, long_arm_r, 1'b0}) - b_p;

  always_comb begin
    case (k_r)
      3'd0:    begin u_nxt = a_n;   v_nxt = b_n;   end
      3'd1:    begin u_nxt = a_p;   v_nxt = b_n;   end
      3'd2:    begin u_nxt = a_p;   v_nxt = v_arm; end
      3'd3:    begin u_nxt = u_arm; v_nxt = v_arm; end
      3'd4:    begin u_nxt = u_arm; v_nxt = b_p;   end
      default: begin u_nxt = a_n;   v_nxt = b_p;   end
    endcase
  end

  // corner stage: local coordinates
  logic e_v_r;
  logic [2:0] e_k_r;
  logic signed [13:0] e_u_r, e_v_loc_r;
  lsv_pkg::pose_t e_pose_r;

  // product stage
  logic m_v_r;
  logic [2:0] m_k_r;
  logic signed [19:0] m_px_r, m_py_r;
  logic signed [F+15:0] m_uc_r, m_vs_r, m_us_r, m_vc_r;

  // rounding stage
  logic n_v_r;
  logic [2:0] n_k_r;
  logic signed [19:0] n_px_r, n_py_r, n_dx_r, n_dy_r;

  logic signed [F+19:0] rx, ry;
  logic signed [20:0] sx, sy;

  assign rx = (F+20)'(($signed((F+20)'(m_uc_r)) - $signed((F+20)'(m_vs_r))) <<< 3)
              + $signed((F+20)'(1) <<< (F - 1));
  assign ry = (F+20)'(($signed((F+20)'(m_us_r)) + $signed((F+20)'(m_vc_r))) <<< 3)
              + $signed((F+20)'(1) <<< (F - 1));
  assign sx = 21'(n_px_r) + 21'(n_dx_r);
  assign sy = 21'(n_py_r) + 21'(n_dy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r     <= 1'b0;
      m_v_r     <= 1'b0;
      n_v_r     <= 1'b0;
      out_valid <= 1'b0;
    end else if (back_en) begin
      e_v_r     <= hold_v_r;
      m_v_r     <= e_v_r;
      n_v_r     <= m_v_r;
      out_valid <= n_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      e_k_r     <= k_r;
      e_u_r     <= u_nxt;
      e_v_loc_r <= v_nxt;
      e_pose_r  <= hold_r;

      m_k_r  <= e_k_r;
      m_px_r <= e_pose_r.px;
      m_py_r <= e_pose_r.py;
      m_uc_r <= (F+16)'(e_u_r * e_pose_r.c);
      m_vs_r <= (F+16)'(e_v_loc_r * e_pose_r.s);
      m_us_r <= (F+16)'(e_u_r * e_pose_r.s);
      m_vc_r <= (F+16)'(e_v_loc_r * e_pose_r.c);

      n_k_r  <= m_k_r;
      n_px_r <= m_px_r;
      n_py_r <= m_py_r;
      n_dx_r <= 20'(rx >>> F);
      n_dy_r <= 20'(ry >>> F);

      out_corner_index <= n_k_r;
      out_last_corner  <= (n_k_r == lsv_pkg::LAST_CORNER);
      if (sx[20] != sx[19]) begin
        out_corner_x <= sx[20] ? 20'sh80000 : 20'sh7FFFF;
      end else begin
        out_corner_x <= sx[19:0];
      end
      if (sy[20] != sy[19]) begin
        out_corner_y <= sy[20] ? 20'sh80000 : 20'sh7FFFF;
      end else begin
        out_corner_y <= sy[19:0];
      end
    end
  end

endmodule

`default_nettype wire
